// ===== hdl/mlrq_pkg.sv =====
// Shared types and constants for the multilevel ready queue.
package mlrq_pkg;

    localparam int NUM_LEVELS_DEF = 32;
    localparam int FIFO_DEPTH_DEF = 8;

    localparam int OP_W     = 2;
    localparam int TASK_W   = 8;
    localparam int LEVEL_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_TOP = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_LVL = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TASK_W-1:0]  task_id;
        logic [LEVEL_W-1:0] level;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TASK_W-1:0]   task_out;
        logic [LEVEL_W-1:0]  top_level;
    } out_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TASK_W-1:0] task_id;
    } cell_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TASK_W-1:0]   task_id;
    } cell_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

// ===== hdl/mlrq_cell.sv =====
// One priority level: shift-register FIFO of task ids with push, pop and remove.
module mlrq_cell #(
    parameter int DEPTH = mlrq_pkg::FIFO_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                exec,
    input  logic                sel,
    input  mlrq_pkg::cell_cmd_t cmd,
    input  logic                found_in,
    output logic                found_out,
    output logic                is_top,
    output mlrq_pkg::cell_rsp_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [mlrq_pkg::TASK_W-1:0] entry_reg  [DEPTH];
    logic [mlrq_pkg::TASK_W-1:0] entry_next [DEPTH];
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        match;
    logic [CNT_W-1:0]            match_idx;
    logic                        nonempty;

    assign nonempty  = (count_reg != '0);
    assign found_out = found_in | nonempty;
    assign is_top    = nonempty & ~found_in;

    // first live entry equal to the task id, nearest the head
    always_comb begin
        match     = 1'b0;
        match_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (!match && (CNT_W'(i) < count_reg) && (entry_reg[i] == cmd.task_id)) begin
                match     = 1'b1;
                match_idx = CNT_W'(i);
            end
        end
    end

    always_comb begin
        entry_next      = entry_reg;
        count_next      = count_reg;
        rsp.status      = mlrq_pkg::STAT_MISS;
        rsp.task_id     = '0;
        case (cmd.op)
            mlrq_pkg::OP_PUSH: begin
                if (count_reg == CNT_W'(DEPTH)) begin
                    rsp.status = mlrq_pkg::STAT_FULL;
                end else begin
                    rsp.status = mlrq_pkg::STAT_OK;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CNT_W'(i) == count_reg) begin
                            entry_next[i] = cmd.task_id;
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            mlrq_pkg::OP_POP_TOP, mlrq_pkg::OP_POP_LVL: begin
                if (nonempty) begin
                    rsp.status  = mlrq_pkg::STAT_OK;
                    rsp.task_id = entry_reg[0];
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        entry_next[i] = entry_reg[i+1];
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            mlrq_pkg::OP_REMOVE: begin
                if (match) begin
                    rsp.status  = mlrq_pkg::STAT_OK;
                    rsp.task_id = cmd.task_id;
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (CNT_W'(i) >= match_idx) begin
                            entry_next[i] = entry_reg[i+1];
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (exec && sel) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec && sel) begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== hdl/multilevel_ready_queue.sv =====
// Multilevel ready queue: top level with sequencer and row of level cells.
// After an input transaction the sequencer executes the command in the addressed
// level, rescans the level chain and then hands the result out.
// A new transaction is accepted only after the result has been taken, since the
// shared sequencer steps through accept, execute, rescan, hand result out.
// Reset: synchronous active-low aresetn empties every level and sets the top
// level to the idle level; stored task ids are not cleared.
module multilevel_ready_queue #(
    parameter int NUM_LEVELS = mlrq_pkg::NUM_LEVELS_DEF,
    parameter int FIFO_DEPTH = mlrq_pkg::FIFO_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mlrq_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mlrq_pkg::out_t m_data
);

    localparam int LVL_IDX_W = $clog2(NUM_LEVELS);

    mlrq_pkg::state_t state_reg, state_next;
    mlrq_pkg::in_t    cmd_reg;
    mlrq_pkg::cell_cmd_t cell_cmd;

    logic [LVL_IDX_W-1:0]         highest_reg;
    logic [LVL_IDX_W-1:0]         top_idx;
    logic [mlrq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [mlrq_pkg::TASK_W-1:0]   task_reg, task_next;
    logic [LVL_IDX_W+mlrq_pkg::LEVEL_W-1:0] top_wide;

    logic                  exec;
    logic                  scan;
    logic [NUM_LEVELS-1:0] sel;
    logic [NUM_LEVELS-1:0] is_top;
    logic [NUM_LEVELS:0]   found;
    mlrq_pkg::cell_rsp_t   rsp [NUM_LEVELS];

    assign cell_cmd.op      = cmd_reg.op;
    assign cell_cmd.task_id = cmd_reg.task_id;
    assign found[0]         = 1'b0;

    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cell
        assign sel[g] = (cmd_reg.op == mlrq_pkg::OP_POP_TOP)
                      ? (highest_reg == LVL_IDX_W'(g))
                      : (32'(cmd_reg.level) == 32'(g));

        mlrq_cell #(
            .DEPTH(FIFO_DEPTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .exec     (exec),
            .sel      (sel[g]),
            .cmd      (cell_cmd),
            .found_in (found[g]),
            .found_out(found[g+1]),
            .is_top   (is_top[g]),
            .rsp      (rsp[g])
        );
    end

    // pick the addressed cell's response; no cell addressed means not found
    always_comb begin
        status_next = mlrq_pkg::STAT_MISS;
        task_next   = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (sel[i]) begin
                status_next = rsp[i].status;
                task_next   = rsp[i].task_id;
            end
        end
    end

    always_comb begin
        top_idx = LVL_IDX_W'(NUM_LEVELS - 1);
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (is_top[i]) begin
                top_idx = LVL_IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mlrq_pkg::S_IDLE: if (s_valid) state_next = mlrq_pkg::S_EXEC;
            mlrq_pkg::S_EXEC: state_next = mlrq_pkg::S_SCAN;
            mlrq_pkg::S_SCAN: state_next = mlrq_pkg::S_DONE;
            mlrq_pkg::S_DONE: if (m_ready) state_next = mlrq_pkg::S_IDLE;
            default:          state_next = mlrq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        exec    = 1'b0;
        scan    = 1'b0;
        case (state_reg)
            mlrq_pkg::S_IDLE: s_ready = 1'b1;
            mlrq_pkg::S_EXEC: exec    = 1'b1;
            mlrq_pkg::S_SCAN: scan    = 1'b1;
            mlrq_pkg::S_DONE: m_valid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mlrq_pkg::S_IDLE;
            highest_reg <= LVL_IDX_W'(NUM_LEVELS - 1);
        end else begin
            state_reg <= state_next;
            if (scan) begin
                highest_reg <= top_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_data;
        end
        if (exec) begin
            status_reg <= status_next;
            task_reg   <= task_next;
        end
    end

    assign top_wide         = {{mlrq_pkg::LEVEL_W{1'b0}}, highest_reg};
    assign m_data.status    = status_reg;
    assign m_data.task_out  = task_reg;
    assign m_data.top_level = top_wide[mlrq_pkg::LEVEL_W-1:0];

endmodule
